// ===== rtl/char_lcd_i2c_expander_writer_macros.svh =====
// Assertion macros shared by the LCD expander writer modules.
// Expects clk and rst (synchronous, active high) in the scope of each use.
`ifndef CHAR_LCD_I2C_EXPANDER_WRITER_MACROS_SVH
`define CHAR_LCD_I2C_EXPANDER_WRITER_MACROS_SVH

// Same-cycle implication.
`define LCDW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LCDW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lcdw_pkg.sv =====
// Shared types and constants for the LCD expander writer.
// No dependencies; used by every module of the block.
package lcdw_pkg;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_RAW    = 3'd0,
    OP_CURSOR = 3'd1,
    OP_DEC3   = 3'd2,
    OP_DEC4   = 3'd3,
    OP_HEX2   = 3'd4,
    OP_HEX4   = 3'd5,
    OP_THOU   = 3'd6
  } op_t;

  // Front-end converter states.
  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_CONV = 2'd1,
    FR_EMIT = 2'd2
  } front_state_t;

  localparam int        MAX_CHARS  = 5;
  localparam int        CONV_STEPS = 16;
  localparam logic [6:0] ADDR_RESET = 7'd39;

  // One classified request: up to five LCD bytes, first at index 0.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                nbytes;
    logic                      rs;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/lcdw_front.sv =====
// Front end: accepts requests and turns them into LCD byte lists.
// Uses lcdw_pkg and the assertion macros; feeds lcdw_queue.
`include "char_lcd_i2c_expander_writer_macros.svh"

module lcdw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic [15:0]        value,
  input  logic               rs,
  input  logic               line,
  input  logic [5:0]         column,
  input  lcdw_pkg::q_status_t q_stat,
  output logic               push,
  output lcdw_pkg::entry_t   push_entry
);

  localparam int          SW        = $clog2(lcdw_pkg::CONV_STEPS);
  localparam logic [7:0]  ASCII_0   = 8'h30;
  localparam logic [7:0]  ASCII_A10 = 8'h37;
  localparam logic [7:0]  ASCII_CMA = 8'h2C;
  localparam logic [7:0]  CUR_BASE  = 8'h80;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = ASCII_0 + {4'b0, n};
    else           r = ASCII_A10 + {4'b0, n};
    return r;
  endfunction

  // Double-dabble adjust: add 3 to every BCD digit of 5 or more.
  function automatic logic [19:0] bcd_adj(input logic [19:0] b);
    logic [19:0] r;
    r = b;
    for (int i = 0; i < 5; i++) begin
      if (b[i*4 +: 4] >= 4'd5) r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
    end
    return r;
  endfunction

  lcdw_pkg::front_state_t state, state_next;
  logic [2:0]        op_r;
  logic [15:0]       sh;
  logic [19:0]       bcd, bcd_step;
  logic [SW-1:0]     cnt;
  logic              pend_valid, pend_free, pend_load, accept, is_dec, is_op;
  lcdw_pkg::entry_t  pend, direct_entry, dec_entry;
  logic [6:0]        thou;
  logic [6:0]        cur_addr;

  assign push      = pend_valid && !q_stat.full;
  assign pend_free = !pend_valid || push;
  assign in_stall  = (state != lcdw_pkg::FR_IDLE) || !pend_free;
  assign accept    = in_valid && !in_stall;
  assign is_dec    = op inside {lcdw_pkg::OP_DEC3, lcdw_pkg::OP_DEC4, lcdw_pkg::OP_THOU};
  assign is_op     = op inside {lcdw_pkg::OP_RAW, lcdw_pkg::OP_CURSOR, lcdw_pkg::OP_HEX2,
                                lcdw_pkg::OP_HEX4};
  assign pend_load = (accept && is_op) || (state == lcdw_pkg::FR_EMIT && pend_free);
  assign push_entry = pend;

  assign bcd_step = bcd_adj(bcd);
  assign cur_addr = {line, 6'b0} + {1'b0, column};
  // Leading quotient can exceed 9: ten-thousands * 10 + thousands.
  assign thou = {bcd[19:16], 3'b0} + {2'b0, bcd[19:16], 1'b0} + {3'b0, bcd[15:12]};

  // Entries for requests needing no conversion.
  always_comb begin
    direct_entry    = '0;
    direct_entry.rs = 1'b1;
    case (op)
      lcdw_pkg::OP_RAW: begin
        direct_entry.chars[0] = value[7:0];
        direct_entry.nbytes   = 3'd1;
        direct_entry.rs       = rs;
      end
      lcdw_pkg::OP_CURSOR: begin
        direct_entry.chars[0] = CUR_BASE | {1'b0, cur_addr};
        direct_entry.nbytes   = 3'd1;
        direct_entry.rs       = 1'b0;
      end
      lcdw_pkg::OP_HEX2: begin
        direct_entry.chars[0] = hex_char(value[7:4]);
        direct_entry.chars[1] = hex_char(value[3:0]);
        direct_entry.nbytes   = 3'd2;
      end
      lcdw_pkg::OP_HEX4: begin
        direct_entry.chars[0] = hex_char(value[15:12]);
        direct_entry.chars[1] = hex_char(value[11:8]);
        direct_entry.chars[2] = hex_char(value[7:4]);
        direct_entry.chars[3] = hex_char(value[3:0]);
        direct_entry.nbytes   = 3'd4;
      end
      default: direct_entry.nbytes = 3'd0;
    endcase
  end

  // Entries built from the finished BCD digits.
  always_comb begin
    dec_entry    = '0;
    dec_entry.rs = 1'b1;
    case (op_r)
      lcdw_pkg::OP_DEC3: begin
        dec_entry.chars[0] = ASCII_0 + {4'b0, bcd[11:8]};
        dec_entry.chars[1] = ASCII_0 + {4'b0, bcd[7:4]};
        dec_entry.chars[2] = ASCII_0 + {4'b0, bcd[3:0]};
        dec_entry.nbytes   = 3'd3;
      end
      lcdw_pkg::OP_DEC4: begin
        dec_entry.chars[0] = ASCII_0 + {1'b0, thou};
        dec_entry.chars[1] = ASCII_0 + {4'b0, bcd[11:8]};
        dec_entry.chars[2] = ASCII_0 + {4'b0, bcd[7:4]};
        dec_entry.chars[3] = ASCII_0 + {4'b0, bcd[3:0]};
        dec_entry.nbytes   = 3'd4;
      end
      default: begin
        dec_entry.chars[0] = ASCII_0 + {1'b0, thou};
        dec_entry.chars[1] = ASCII_CMA;
        dec_entry.chars[2] = ASCII_0 + {4'b0, bcd[11:8]};
        dec_entry.chars[3] = ASCII_0 + {4'b0, bcd[7:4]};
        dec_entry.chars[4] = ASCII_0 + {4'b0, bcd[3:0]};
        dec_entry.nbytes   = 3'd5;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      lcdw_pkg::FR_IDLE: if (accept && is_dec) state_next = lcdw_pkg::FR_CONV;
      lcdw_pkg::FR_CONV: if (cnt == SW'(lcdw_pkg::CONV_STEPS - 1)) begin
        state_next = lcdw_pkg::FR_EMIT;
      end
      lcdw_pkg::FR_EMIT: if (pend_free) state_next = lcdw_pkg::FR_IDLE;
      default: state_next = lcdw_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lcdw_pkg::FR_IDLE;
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_load || (pend_valid && !push);
      if (state == lcdw_pkg::FR_CONV) cnt <= cnt + 1'b1;
      else                            cnt <= '0;
    end
  end

  // Datapath: converter shift registers and pending entry.
  always_ff @(posedge clk) begin
    if (accept && is_dec) begin
      op_r <= op;
      bcd  <= '0;
      sh   <= (op == lcdw_pkg::OP_DEC3) ? {8'b0, value[7:0]} : value;
    end else if (state == lcdw_pkg::FR_CONV) begin
      bcd <= {bcd_step[18:0], sh[15]};
      sh  <= {sh[14:0], 1'b0};
    end
    if (accept && is_op)                                   pend <= direct_entry;
    else if (state == lcdw_pkg::FR_EMIT && pend_free)      pend <= dec_entry;
  end

  `LCDW_ASSERT_IMP(a_conv_stalls, state == lcdw_pkg::FR_CONV, in_stall,
                   "input taken during conversion")
  `LCDW_ASSERT_NXT(a_pend_kept, pend_valid && q_stat.full, pend_valid,
                   "pending entry dropped while queue full")

endmodule

// ===== rtl/lcdw_queue.sv =====
// Small entry queue between the front end and the sequencer.
// Uses lcdw_pkg entry and status types.
module lcdw_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcdw_pkg::entry_t    push_entry,
  input  logic                pop,
  output lcdw_pkg::entry_t    head,
  output lcdw_pkg::q_status_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lcdw_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign head             = mem[rd_ptr];
  assign q_stat.not_empty = (count != '0);
  assign q_stat.full      = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

endmodule

// ===== rtl/lcdw_back.sv =====
// Back end: walks each queued entry byte by nibble by enable phase.
// Uses lcdw_pkg and the assertion macros; reads the head of lcdw_queue.
`include "char_lcd_i2c_expander_writer_macros.svh"

module lcdw_back (
  input  logic                clk,
  input  logic                rst,
  input  lcdw_pkg::entry_t    head,
  input  lcdw_pkg::q_status_t q_stat,
  input  logic [6:0]          i2c_address,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          expander_byte,
  output logic [6:0]          bus_address,
  output logic                last
);

  localparam logic [1:0] PH_LOW_A = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW_B = 2'd2;

  logic [2:0] byte_idx;
  logic       nib_sel;
  logic [1:0] phase;
  logic       out_load, step, step_last;
  logic [7:0] cur_byte;
  logic [3:0] nib;

  assign out_load  = !out_valid || !out_stall;
  assign step      = out_load && q_stat.not_empty;
  assign cur_byte  = head.chars[byte_idx];
  assign nib       = nib_sel ? cur_byte[3:0] : cur_byte[7:4];
  assign step_last = (byte_idx == head.nbytes - 3'd1) && nib_sel && (phase == PH_LOW_B);
  assign pop       = step && step_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
      nib_sel   <= 1'b0;
      phase     <= PH_LOW_A;
    end else begin
      if (out_load) out_valid <= q_stat.not_empty;
      if (step) begin
        if (phase != PH_LOW_B) begin
          phase <= phase + 2'd1;
        end else begin
          phase   <= PH_LOW_A;
          nib_sel <= !nib_sel;
          if (step_last)    byte_idx <= '0;
          else if (nib_sel) byte_idx <= byte_idx + 3'd1;
        end
      end
    end
  end

  // Backlight on, read/write low, enable high only in the middle phase.
  always_ff @(posedge clk) begin
    if (step) begin
      expander_byte <= {nib, 1'b1, phase == PH_HIGH, 1'b0, head.rs};
      bus_address   <= i2c_address;
      last          <= step_last;
    end
  end

  `LCDW_ASSERT_NXT(a_pop_rewinds, pop, byte_idx == 3'd0 && !nib_sel && phase == PH_LOW_A,
                   "sequencer not rewound after entry")
  `LCDW_ASSERT_IMP(a_last_enable_low, out_valid && last, !expander_byte[2] && expander_byte[3],
                   "final item must have enable low and backlight on")

endmodule

// ===== rtl/char_lcd_i2c_expander_writer.sv =====
// Top level of the character LCD writer over an I2C port expander.
// Uses lcdw_pkg, lcdw_front, lcdw_queue and lcdw_back.
//
// Turns each display request into the run of expander bytes that drive an
// HD44780-style LCD in 4-bit mode: every LCD byte goes out high nibble then
// low nibble, each nibble as three items (enable low, high, low), with the
// backlight bit set and read/write low. A raw byte or cursor placement gives
// 6 items, hex2 12, dec3 18, dec4 and hex4 24, thousandths (d,ddd) 30; op
// code 7 gives none. The sequencer emits one item per cycle while the output
// is not stalled. The front end classifies byte, cursor and hex requests
// without conversion; decimal requests run a 16-step binary-to-BCD converter,
// one bit per cycle, then hand off. A short entry queue sits between the two,
// so the front end takes and converts the next request while the sequencer is
// still emitting, and a stalled output backs up the queue and, once it is
// full, the request side. The bus address is sampled from the configuration
// register as each item is produced; write it only while the block is idle.
module char_lcd_i2c_expander_writer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [15:0] value,
  input  logic        rs,
  input  logic        line,
  input  logic [5:0]  column,
  // expander item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  expander_byte,
  output logic [6:0]  bus_address,
  output logic        last
);

  logic [6:0]          i2c_address;
  logic                push, pop;
  lcdw_pkg::entry_t    push_entry, head;
  lcdw_pkg::q_status_t q_stat;

  // Bus address register; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      i2c_address <= lcdw_pkg::ADDR_RESET;
    end else if (cfg_write) begin
      i2c_address <= cfg_data;
    end
  end

  // Front end: handshake, classification, decimal conversion.
  lcdw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .rs         (rs),
    .line       (line),
    .column     (column),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouples classification from emission.
  lcdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Back end: byte / nibble / enable-phase sequencer with output register.
  lcdw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .i2c_address   (i2c_address),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .expander_byte (expander_byte),
    .bus_address   (bus_address),
    .last          (last)
  );

endmodule

// ===== tb/lcdw_expander_check.sv =====
// Watches both channels of the LCD expander writer, predicts the expander items
// of each request and compares them in order. Depends on lcdw_pkg.
module lcdw_expander_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  op,
  input  logic [15:0] value,
  input  logic        rs,
  input  logic        line,
  input  logic [5:0]  column,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  expander_byte,
  input  logic [6:0]  bus_address,
  input  logic        last,
  output int          errors,
  output int          outstanding,
  output int          checked
);

  localparam int         ASCII_ZERO  = 'h30;
  localparam int         ASCII_A     = 'h41;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam logic [7:0] CURSOR_CMD  = 8'h80;
  localparam logic [7:0] BACKLIGHT   = 8'h08;
  localparam logic [7:0] ENABLE      = 8'h04;

  typedef struct packed {
    logic [7:0] xbyte;
    logic [6:0] addr;
    logic       last;
  } expander_item_t;

  expander_item_t expected_items[$];
  logic [6:0]     shadow_addr;

  initial begin
    errors = 0;
    outstanding = 0;
    checked = 0;
    shadow_addr = lcdw_pkg::ADDR_RESET;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'(ASCII_ZERO + int'(n)) : 8'(ASCII_A + int'(n) - 10);
  endfunction

  // LCD bytes of one request, each split into two nibbles of three items.
  function automatic void predict_expander_items(input logic [2:0] op_code,
                                                 input logic [15:0] val,
                                                 input logic rs_in,
                                                 input logic line_in,
                                                 input logic [5:0] col);
    logic [7:0] chars [5];
    int         nchars;
    logic       char_rs;
    int         lo_n;
    int         full_n;
    logic [3:0] nib;
    logic [7:0] base;
    expander_item_t item;
    lo_n = int'(val[7:0]);
    full_n = int'(val);
    nchars = 0;
    char_rs = 1'b1;
    case (op_code)
      lcdw_pkg::OP_RAW: begin
        chars[0] = val[7:0];
        nchars = 1;
        char_rs = rs_in;
      end
      lcdw_pkg::OP_CURSOR: begin
        chars[0] = CURSOR_CMD | ({1'b0, line_in, 6'd0} + {2'b00, col});
        nchars = 1;
        char_rs = 1'b0;
      end
      lcdw_pkg::OP_DEC3: begin
        chars[0] = 8'(ASCII_ZERO + lo_n / 100);
        chars[1] = 8'(ASCII_ZERO + (lo_n % 100) / 10);
        chars[2] = 8'(ASCII_ZERO + lo_n % 10);
        nchars = 3;
      end
      lcdw_pkg::OP_DEC4: begin
        chars[0] = 8'(ASCII_ZERO + full_n / 1000);
        chars[1] = 8'(ASCII_ZERO + (full_n % 1000) / 100);
        chars[2] = 8'(ASCII_ZERO + (full_n % 100) / 10);
        chars[3] = 8'(ASCII_ZERO + full_n % 10);
        nchars = 4;
      end
      lcdw_pkg::OP_THOU: begin
        chars[0] = 8'(ASCII_ZERO + full_n / 1000);
        chars[1] = ASCII_COMMA;
        chars[2] = 8'(ASCII_ZERO + (full_n % 1000) / 100);
        chars[3] = 8'(ASCII_ZERO + (full_n % 100) / 10);
        chars[4] = 8'(ASCII_ZERO + full_n % 10);
        nchars = 5;
      end
      lcdw_pkg::OP_HEX2: begin
        chars[0] = hex_char(val[7:4]);
        chars[1] = hex_char(val[3:0]);
        nchars = 2;
      end
      lcdw_pkg::OP_HEX4: begin
        chars[0] = hex_char(val[15:12]);
        chars[1] = hex_char(val[11:8]);
        chars[2] = hex_char(val[7:4]);
        chars[3] = hex_char(val[3:0]);
        nchars = 4;
      end
      default: nchars = 0;
    endcase
    for (int c = 0; c < nchars; c++) begin
      for (int half = 0; half < 2; half++) begin
        nib = (half == 0) ? chars[c][7:4] : chars[c][3:0];
        base = {nib, 3'b000, char_rs} | BACKLIGHT;
        for (int k = 0; k < 3; k++) begin
          item.xbyte = (k == 1) ? (base | ENABLE) : base;
          item.addr = shadow_addr;
          item.last = (c == nchars - 1) && (half == 1) && (k == 2);
          expected_items.push_back(item);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    expander_item_t want;
    if (rst) begin
      shadow_addr = lcdw_pkg::ADDR_RESET;
      expected_items.delete();
    end else begin
      if (cfg_write)
        shadow_addr = cfg_data;
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_items.size() == 0) begin
          $error("unexpected expander item %h (addr %h, last %b)",
                 expander_byte, bus_address, last);
          errors++;
        end else begin
          want = expected_items.pop_front();
          if (expander_byte !== want.xbyte) begin
            $error("expander_byte: expected %h, got %h", want.xbyte, expander_byte);
            errors++;
          end
          if (bus_address !== want.addr) begin
            $error("bus_address: expected %h, got %h", want.addr, bus_address);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_expander_items(op, value, rs, line, column);
    end
    outstanding = expected_items.size();
  end

endmodule

// ===== tb/char_lcd_i2c_expander_writer_tb.sv =====
// Top of the LCD expander writer testbench: clock, reset, request stimulus,
// output stall pattern, watchdog and verdict. Uses lcdw_pkg and lcdw_expander_check.
module char_lcd_i2c_expander_writer_tb;

  // op code the block ignores (no items come out)
  localparam logic [2:0] OP_NONE        = 3'd7;
  // covers the 16-step BCD conversion plus the entry queue draining
  localparam int         SETTLE_CYCLES  = 64;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [6:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op;
  logic [15:0] value;
  logic        rs;
  logic        line;
  logic [5:0]  column;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  expander_byte;
  logic [6:0]  bus_address;
  logic        last;

  int errors;
  int outstanding;
  int checked;

  int requests_sent;
  int ignored_sent;
  int burst_left;
  int idle_cycles;
  bit hold_req;
  bit hold_done;

  char_lcd_i2c_expander_writer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .rs           (rs),
    .line         (line),
    .column       (column),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .expander_byte(expander_byte),
    .bus_address  (bus_address),
    .last         (last)
  );

  // Predicts and compares every item; we only read back the tallies.
  lcdw_expander_check byte_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .value        (value),
    .rs           (rs),
    .line         (line),
    .column       (column),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .expander_byte(expander_byte),
    .bus_address  (bus_address),
    .last         (last),
    .errors       (errors),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: any cycle with a handshake on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: segments of no stall, light, heavy or periodic stall. Once the
  // stimulus asks for it, one long hold-off so the entry queue fills and the
  // request side backs up.
  initial begin
    int mode;
    int seg_len;
    out_stall <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 60);
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ((i % 5) >= 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // One request: requests come in back-to-back bursts, with a gap of valid low before each burst.
  task automatic send_request(input logic [2:0] o, input logic [15:0] v,
                              input logic r, input logic l, input logic [5:0] c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    rs <= r;
    line <= l;
    column <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (o == OP_NONE)
      ignored_sent++;
    else
      requests_sent++;
  endtask

  // Sender pause: nothing offered until every expected item has come out,
  // plus the settle time; an unused op code starts no conversion.
  // It first waits for a clock edge so the checker has counted the last accepted request.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [6:0] addr);
    cfg_write <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random requests, mostly valid ops; values lean toward the edges where
  // digit and nibble boundaries live. Ignored op codes do not count.
  task automatic run_random(input int count);
    int         done_n;
    logic [2:0] o;
    logic [15:0] v;
    done_n = 0;
    while (done_n < count) begin
      o = ($urandom_range(0, 15) == 0) ? OP_NONE : 3'($urandom_range(0, 6));
      case ($urandom_range(0, 5))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        2: v = 16'($urandom_range(0, 255));
        3: v = 16'($urandom_range(9990, 10010));
        default: v = 16'($urandom_range(0, 65535));
      endcase
      send_request(o, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   6'($urandom_range(0, 63)));
      if (o != OP_NONE)
        done_n++;
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 7'd0;
    in_valid <= 1'b0;
    op <= lcdw_pkg::OP_RAW;
    value <= 16'd0;
    rs <= 1'b0;
    line <= 1'b0;
    column <= 6'd0;
    hold_req = 1'b0;
    burst_left = 0;
    requests_sent = 0;
    ignored_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset bus address.
    // raw command and data bytes; upper value bits must be ignored
    send_request(lcdw_pkg::OP_RAW, 16'h0000, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_RAW, 16'hA5FF, 1'b1, 1'b1, 6'd63);
    send_request(lcdw_pkg::OP_RAW, 16'h005A, 1'b1, 1'b0, 6'd0);
    // cursor corners; cursor is always a command even with rs high
    send_request(lcdw_pkg::OP_CURSOR, 16'hFFFF, 1'b1, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_CURSOR, 16'h0000, 1'b0, 1'b1, 6'd63);
    send_request(lcdw_pkg::OP_CURSOR, 16'h0000, 1'b0, 1'b0, 6'd63);
    // dec3 uses only the low byte, hundreds digit at most 2
    send_request(lcdw_pkg::OP_DEC3, 16'h0000, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_DEC3, 16'hFFFF, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_DEC3, 16'h3364, 1'b0, 1'b0, 6'd0);
    // dec4 with leading digit 0, 9, exactly 10 and the largest (65)
    send_request(lcdw_pkg::OP_DEC4, 16'd0, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_DEC4, 16'd9999, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_DEC4, 16'd10000, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_DEC4, 16'hFFFF, 1'b0, 1'b0, 6'd0);
    // thousandths
    send_request(lcdw_pkg::OP_THOU, 16'd0, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_THOU, 16'd1234, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_THOU, 16'hFFFF, 1'b0, 1'b0, 6'd0);
    // hex: digits and letters, upper byte ignored by hex2
    send_request(lcdw_pkg::OP_HEX2, 16'h12AB, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_HEX2, 16'hFF09, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_HEX4, 16'h0000, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_HEX4, 16'hFFFF, 1'b0, 1'b0, 6'd0);
    send_request(lcdw_pkg::OP_HEX4, 16'h9A5F, 1'b0, 1'b0, 6'd0);
    // unused op code: must produce nothing, then a normal one right behind
    send_request(OP_NONE, 16'hFFFF, 1'b1, 1'b1, 6'd63);
    send_request(lcdw_pkg::OP_RAW, 16'h00C3, 1'b1, 1'b0, 6'd0);
    wait_idle();

    write_address(7'd0);
    run_random(65);
    wait_idle();

    // long receiver hold-off lands somewhere in this batch
    write_address(7'd127);
    hold_req = 1'b1;
    run_random(65);
    wait_idle();

    write_address(7'($urandom_range(1, 126)));
    run_random(45);
    wait_idle();

    $display("covered %0d requests (%0d ignored op codes), %0d expander items checked",
             requests_sent, ignored_sent, checked);
    $display("bus addresses 39, 0, 127 and one random; receiver hold-off %0s",
             hold_done ? "done" : "missed");
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== char_lcd_i2c_expander_writer.f =====
+incdir+rtl
rtl/lcdw_pkg.sv
rtl/lcdw_front.sv
rtl/lcdw_queue.sv
rtl/lcdw_back.sv
rtl/char_lcd_i2c_expander_writer.sv
tb/lcdw_expander_check.sv
tb/char_lcd_i2c_expander_writer_tb.sv
